[rtl/core/unicode_to_gsm7_encoder_defines.svh]
// Assertion macros for the Unicode to GSM 7-bit encoder.
`ifndef UNICODE_TO_GSM7_ENCODER_DEFINES_SVH
`define UNICODE_TO_GSM7_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define U2G7_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define U2G7_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define U2G7_ASSERT(label, prop, msg)
`define U2G7_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/core/u2g7_pkg.sv]
// Types, codes and character tables for the Unicode to GSM 7-bit encoder.
`default_nettype none

package u2g7_pkg;

  localparam logic [1:0] ST_ONE        = 2'd0;
  localparam logic [1:0] ST_PAIR       = 2'd1;
  localparam logic [1:0] ST_NOROOM     = 2'd2;
  localparam logic [1:0] ST_UNMAPPABLE = 2'd3;

  localparam logic [6:0] ESC_CODE = 7'h1B;

  typedef struct packed {
    logic [15:0] code_point;
    logic        room_for_two;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] first_byte;
    logic [6:0] second_byte;
  } out_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } lut_t;

  // Characters shared by ASCII and GSM, plus LF and CR.
  function automatic logic passes_through(input logic [15:0] cp);
    return (cp == 16'h000A) || (cp == 16'h000D) ||
           (cp >= 16'h0020 && cp <= 16'h0023) ||
           (cp >= 16'h0025 && cp <= 16'h003F) ||
           (cp >= 16'h0041 && cp <= 16'h005A) ||
           (cp >= 16'h0061 && cp <= 16'h007A);
  endfunction

  // Single-code characters, accented folds and Greek capitals.
  function automatic lut_t map_single(input logic [15:0] cp);
    lut_t r;
    r.hit = 1'b1;
    unique case (cp)
      16'h0024: r.code = 7'h02;
      16'h0040: r.code = 7'h00;
      16'h005F: r.code = 7'h11;
      16'h00A1: r.code = 7'h40;
      16'h00A3: r.code = 7'h01;
      16'h00A4: r.code = 7'h24;
      16'h00A5: r.code = 7'h03;
      16'h00A7: r.code = 7'h5F;
      16'h00B0: r.code = 7'h24; // degree sign shares the currency code
      16'h00BF: r.code = 7'h60;
      16'h00C4: r.code = 7'h5B;
      16'h00C5: r.code = 7'h0E;
      16'h00C6: r.code = 7'h1C;
      16'h00C7: r.code = 7'h09;
      16'h00C9: r.code = 7'h1F;
      16'h00D1: r.code = 7'h5D;
      16'h00D6: r.code = 7'h5C;
      16'h00D8: r.code = 7'h0B;
      16'h00DC: r.code = 7'h5E;
      16'h00DF: r.code = 7'h1E;
      16'h00E0: r.code = 7'h7F;
      16'h00E4: r.code = 7'h7B;
      16'h00E5: r.code = 7'h0F;
      16'h00E6: r.code = 7'h1D;
      16'h00E7: r.code = 7'h09;
      16'h00E8: r.code = 7'h04;
      16'h00E9: r.code = 7'h05;
      16'h00EC: r.code = 7'h07;
      16'h00F1: r.code = 7'h7D;
      16'h00F2: r.code = 7'h08;
      16'h00F6: r.code = 7'h7C;
      16'h00F8: r.code = 7'h0C;
      16'h00F9: r.code = 7'h06;
      16'h00FC: r.code = 7'h7E;
      // one-way folds to the base letter
      16'h00C0, 16'h00C1, 16'h00C2, 16'h00C3: r.code = 7'h41;
      16'h00C8, 16'h00CA, 16'h00CB:           r.code = 7'h45;
      16'h00CC, 16'h00CD, 16'h00CE, 16'h00CF: r.code = 7'h49;
      16'h00D2, 16'h00D3, 16'h00D4, 16'h00D5: r.code = 7'h4F;
      16'h00D9, 16'h00DA, 16'h00DB:           r.code = 7'h55;
      16'h00DD:                               r.code = 7'h59;
      16'h00E1, 16'h00E2, 16'h00E3:           r.code = 7'h61;
      16'h00EA, 16'h00EB:                     r.code = 7'h65;
      16'h00ED, 16'h00EE, 16'h00EF:           r.code = 7'h69;
      16'h00F3, 16'h00F4, 16'h00F5:           r.code = 7'h6F;
      16'h00FA, 16'h00FB:                     r.code = 7'h75;
      16'h00FD, 16'h00FF:                     r.code = 7'h79;
      // Greek capitals
      16'h0394: r.code = 7'h10;
      16'h03A6: r.code = 7'h12;
      16'h0393: r.code = 7'h13;
      16'h039B: r.code = 7'h14;
      16'h03A9: r.code = 7'h15;
      16'h03A0: r.code = 7'h16;
      16'h03A8: r.code = 7'h17;
      16'h03A3: r.code = 7'h18;
      16'h0398: r.code = 7'h19;
      16'h039E: r.code = 7'h1A;
      16'h0391: r.code = 7'h41;
      16'h0392: r.code = 7'h42;
      16'h0395: r.code = 7'h45;
      16'h0397: r.code = 7'h48;
      16'h0399: r.code = 7'h49;
      16'h039A: r.code = 7'h4B;
      16'h039C: r.code = 7'h4D;
      16'h039D: r.code = 7'h4E;
      16'h039F: r.code = 7'h4F;
      16'h03A1: r.code = 7'h50;
      16'h03A4: r.code = 7'h54;
      16'h03A5: r.code = 7'h55;
      16'h03A7: r.code = 7'h58;
      16'h0396: r.code = 7'h5A;
      default: begin
        r.hit  = 1'b0;
        r.code = 7'h00;
      end
    endcase
    return r;
  endfunction

  // Extension-table characters, sent after an escape.
  function automatic lut_t map_escape(input logic [15:0] cp);
    lut_t r;
    r.hit = 1'b1;
    unique case (cp)
      16'h005B: r.code = 7'h3C;
      16'h005C: r.code = 7'h2F;
      16'h005D: r.code = 7'h3E;
      16'h005E: r.code = 7'h14;
      16'h007B: r.code = 7'h28;
      16'h007C: r.code = 7'h40;
      16'h007D: r.code = 7'h29;
      16'h007E: r.code = 7'h3D;
      16'h20AC: r.code = 7'h65; // euro sign
      default: begin
        r.hit  = 1'b0;
        r.code = 7'h00;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/unicode_to_gsm7_encoder.sv]
// Unicode to GSM 7-bit default alphabet encoder, top level.
`default_nettype none

`include "unicode_to_gsm7_encoder_defines.svh"

// Encodes the low 16 bits of a Unicode code point into the GSM 7-bit default
// alphabet: one byte, an escape pair (0x1B then an extension code), a
// no-room status when a pair is needed but room_for_two is low, or an
// unmappable status. One transaction is taken on every cycle that start is
// high; busy never rises, so the block runs at one code point per clock.
// Each result appears on result_o for exactly one cycle with valid_o high,
// after passing through the input register, then the table lookup, then the
// result register. The receiver cannot stall the block, so it must take every
// result on the cycle it is shown. Results come out in the order the
// transactions went in. No state is kept between code points.
module unicode_to_gsm7_encoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  u2g7_pkg::in_t   item_i,
  output logic            valid_o,
  output u2g7_pkg::out_t  result_o
);

  import u2g7_pkg::*;

  // Input register
  logic in_vld_q;
  in_t  in_q;

  // Result register
  logic out_vld_q;
  out_t res_q, res_d;

  lut_t single_hit, esc_hit;

  // Nothing ever holds off the sender.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  // Lookup: pass-through beats the single table, which beats the escapes.
  always_comb begin
    single_hit = map_single(in_q.code_point);
    esc_hit    = map_escape(in_q.code_point);
    res_d      = '{status: ST_UNMAPPABLE, first_byte: 7'h00, second_byte: 7'h00};
    priority if (passes_through(in_q.code_point)) begin
      res_d.status     = ST_ONE;
      res_d.first_byte = in_q.code_point[6:0];
    end else if (single_hit.hit) begin
      res_d.status     = ST_ONE;
      res_d.first_byte = single_hit.code;
    end else if (esc_hit.hit) begin
      if (in_q.room_for_two) begin
        res_d.status      = ST_PAIR;
        res_d.first_byte  = ESC_CODE;
        res_d.second_byte = esc_hit.code;
      end else begin
        res_d.status = ST_NOROOM;
      end
    end else begin
      res_d.status = ST_UNMAPPABLE;
    end
  end

  assign valid_o  = out_vld_q;
  assign result_o = res_q;

  // Every transaction yields its result, through the input and result registers.
  `U2G7_ASSERT(a_latency, start |-> ##2 valid_o, "result missing two cycles after start")
  // An escape pair always leads with the escape code.
  `U2G7_ASSERT(a_pair_esc,
    valid_o && result_o.status == ST_PAIR |-> result_o.first_byte == ESC_CODE,
    "escape pair without escape code")
  // Only an escape pair carries a second byte.
  `U2G7_ASSERT(a_second_zero,
    valid_o && result_o.status != ST_PAIR |-> result_o.second_byte == 7'h00,
    "stray second byte")

endmodule

`default_nettype wire
